### sv/qwt_pkg.sv
// ----------------------------------------------------------------------------
// qwt_pkg: shared types and constants of the quoted word tokenizer
// Character codes, line limit, the result record and the error codes.
// ----------------------------------------------------------------------------
`default_nettype none

package qwt_pkg;

  localparam int unsigned LINE_LENGTH = 256;
  // Positions are reported in 8/9-bit fields, so a line holds at most 256 characters.
  localparam logic [8:0] LINE_LIMIT = (LINE_LENGTH > 256) ? 9'd256 : 9'(LINE_LENGTH);

  localparam logic [8:0] WORD_LIMIT_RESET = 9'd256;

  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;

  typedef enum logic [1:0] {
    ERR_NONE       = 2'd0,
    ERR_OPEN_QUOTE = 2'd1,
    ERR_WORD_LONG  = 2'd2,
    ERR_LINE_LONG  = 2'd3
  } qwt_err_t;

  typedef enum logic {
    OP_CHAR = 1'b0,
    OP_EOL  = 1'b1
  } qwt_op_t;

  typedef struct packed {
    logic       char_valid;
    logic [7:0] cooked_char;
    logic       word_end;
    logic [7:0] word_start;
    logic [8:0] word_stop;
    logic [8:0] word_length;
    logic       word_quoted;
    qwt_err_t   error_kind;
  } qwt_result_t;

endpackage

`default_nettype wire

### sv/qwt_core.sv
// ----------------------------------------------------------------------------
// qwt_core: tokenizer state and per-character decision
// Holds quote, escape and word state; turns one item into at most one result.
// ----------------------------------------------------------------------------
`default_nettype none

module qwt_core (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                item_go,
  input  wire qwt_pkg::qwt_op_t    item_op,
  input  wire logic [7:0]          item_char,
  input  wire logic [8:0]          word_limit,
  output logic                     res_valid,
  output qwt_pkg::qwt_result_t     res
);

  logic       in_single_r, in_single_nxt;
  logic       in_double_r, in_double_nxt;
  logic       escape_r, escape_nxt;
  logic       in_word_r, in_word_nxt;
  logic       saw_quote_r, saw_quote_nxt;
  logic       discard_r, discard_nxt;
  logic [8:0] cooked_r, cooked_nxt;
  logic [8:0] line_pos_r, line_pos_nxt;
  logic [7:0] start_r, start_nxt;

  logic blank;
  logic do_keep;

  assign blank = (item_char == qwt_pkg::CH_SPACE) || (item_char == qwt_pkg::CH_TAB) ||
                 (item_char == qwt_pkg::CH_CR) || (item_char == qwt_pkg::CH_LF);

  always_comb begin
    in_single_nxt = in_single_r;
    in_double_nxt = in_double_r;
    escape_nxt    = escape_r;
    in_word_nxt   = in_word_r;
    saw_quote_nxt = saw_quote_r;
    discard_nxt   = discard_r;
    cooked_nxt    = cooked_r;
    line_pos_nxt  = line_pos_r;
    start_nxt     = start_r;
    res_valid     = 1'b0;
    res           = '0;
    do_keep       = 1'b0;

    if (item_op == qwt_pkg::OP_EOL) begin
      if (!discard_r) begin
        if (in_single_r || in_double_r) begin
          res_valid      = 1'b1;
          res.error_kind = qwt_pkg::ERR_OPEN_QUOTE;
        end else if (in_word_r) begin
          res_valid        = 1'b1;
          res.word_end     = 1'b1;
          res.word_start   = start_r;
          res.word_stop    = line_pos_r;
          res.word_length  = cooked_r;
          res.word_quoted  = saw_quote_r;
        end
      end
      // start a fresh line
      in_single_nxt = 1'b0;
      in_double_nxt = 1'b0;
      escape_nxt    = 1'b0;
      in_word_nxt   = 1'b0;
      saw_quote_nxt = 1'b0;
      discard_nxt   = 1'b0;
      cooked_nxt    = '0;
      line_pos_nxt  = '0;
      start_nxt     = '0;
    end else if (discard_r) begin
      // drop the rest of the line
    end else if (line_pos_r >= qwt_pkg::LINE_LIMIT) begin
      res_valid      = 1'b1;
      res.error_kind = qwt_pkg::ERR_LINE_LONG;
      discard_nxt    = 1'b1;
    end else begin
      line_pos_nxt = line_pos_r + 9'd1;
      if (escape_r) begin
        escape_nxt = 1'b0;
        do_keep    = 1'b1;
      end else if (in_word_r || !blank) begin
        if (!in_word_r) begin
          in_word_nxt   = 1'b1;
          start_nxt     = line_pos_r[7:0];
          cooked_nxt    = '0;
          saw_quote_nxt = 1'b0;
        end
        if (!in_single_r && !in_double_r && blank) begin
          res_valid       = 1'b1;
          res.word_end    = 1'b1;
          res.word_start  = start_nxt;
          res.word_stop   = line_pos_r;
          res.word_length = cooked_nxt;
          res.word_quoted = saw_quote_nxt;
          in_word_nxt     = 1'b0;
        end else if (!in_single_r && item_char == qwt_pkg::CH_BSLASH) begin
          escape_nxt = 1'b1;
        end else if (!in_double_r && item_char == qwt_pkg::CH_SQUOTE) begin
          saw_quote_nxt = 1'b1;
          in_single_nxt = !in_single_r;
        end else if (!in_single_r && item_char == qwt_pkg::CH_DQUOTE) begin
          saw_quote_nxt = 1'b1;
          in_double_nxt = !in_double_r;
        end else begin
          do_keep = 1'b1;
        end
      end
    end

    if (do_keep) begin
      res_valid = 1'b1;
      if (cooked_nxt >= word_limit) begin
        res.error_kind = qwt_pkg::ERR_WORD_LONG;
        discard_nxt    = 1'b1;
      end else begin
        cooked_nxt      = cooked_nxt + 9'd1;
        res.char_valid  = 1'b1;
        res.cooked_char = item_char;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_single_r <= 1'b0;
      in_double_r <= 1'b0;
      escape_r    <= 1'b0;
      in_word_r   <= 1'b0;
      saw_quote_r <= 1'b0;
      discard_r   <= 1'b0;
      cooked_r    <= '0;
      line_pos_r  <= '0;
      start_r     <= '0;
    end else if (item_go) begin
      in_single_r <= in_single_nxt;
      in_double_r <= in_double_nxt;
      escape_r    <= escape_nxt;
      in_word_r   <= in_word_nxt;
      saw_quote_r <= saw_quote_nxt;
      discard_r   <= discard_nxt;
      cooked_r    <= cooked_nxt;
      line_pos_r  <= line_pos_nxt;
      start_r     <= start_nxt;
    end
  end

endmodule

`default_nettype wire

### sv/qwt_out_buf.sv
// ----------------------------------------------------------------------------
// qwt_out_buf: two-entry result buffer
// Result register plus skid entry, so the core keeps running under a stall until both entries are full.
// ----------------------------------------------------------------------------
`default_nettype none

module qwt_out_buf (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 push,
  input  wire qwt_pkg::qwt_result_t push_data,
  output logic                      full,
  output logic                      pop,
  output logic                      head_valid,
  output qwt_pkg::qwt_result_t      head_data,
  input  wire logic                 head_ready
);

  qwt_pkg::qwt_result_t d0_r, d0_nxt;
  qwt_pkg::qwt_result_t d1_r, d1_nxt;
  logic [1:0]           cnt_r, cnt_nxt;

  assign head_valid = (cnt_r != 2'd0);
  assign head_data  = d0_r;
  assign full       = (cnt_r == 2'd2);
  assign pop        = head_valid && head_ready;

  always_comb begin
    d0_nxt  = d0_r;
    d1_nxt  = d1_r;
    cnt_nxt = cnt_r;
    if (pop) begin
      d0_nxt  = d1_r;
      cnt_nxt = cnt_r - 2'd1;
    end
    if (push) begin
      // write the first free slot after the pop
      if (cnt_nxt == 2'd0) begin
        d0_nxt = push_data;
      end else begin
        d1_nxt = push_data;
      end
      cnt_nxt = cnt_nxt + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    d0_r <= d0_nxt;
    d1_r <= d1_nxt;
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

### sv/quoted_word_tokenizer.sv
// ----------------------------------------------------------------------------
// quoted_word_tokenizer: shell-style word splitter with quotes and escapes
// Input register, tokenizer core and two-entry result buffer.
// ----------------------------------------------------------------------------
// One raw character per input word (in_tlast marks end of line). Each word
// is registered, then decided combinationally by the tokenizer core, which
// updates quote/escape/word state and produces at most one result: a cooked
// character, a word end with its start, stop, length and quoted flag, or an
// error. The block takes one character per clock while the result buffer
// has room; the limit is the single state update per character in the core.
// A two-entry result buffer lets input continue while the output side
// stalls, until both entries are full. The user writes the word length limit
// on the cfg channel only while idle; the block does not enforce it. Reset 256.
`default_nettype none

module quoted_word_tokenizer (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // configuration: max_word_length
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [8:0]  cfg_data,
  // input stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] char_code
  input  wire logic        in_tlast,   // operation (1 = end of line)
  // result stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata,  // [7:0] cooked_char, [15:8] word_start,
                                       // [24:16] word_stop, [33:25] word_length,
                                       // [34] word_quoted, [39:35] zero
  output logic             out_tlast,  // word_end
  output logic [2:0]       out_tuser   // [0] char_valid, [2:1] error_kind
);

  logic [8:0]        word_max_r;
  logic [8:0]        word_limit;
  logic              s1_valid_r;
  qwt_pkg::qwt_op_t  s1_op_r;
  logic [7:0]        s1_char_r;
  logic              s1_go;
  logic              buf_full;
  logic              buf_pop;
  logic              res_valid;

  qwt_pkg::qwt_result_t res;
  qwt_pkg::qwt_result_t head;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_max_r <= qwt_pkg::WORD_LIMIT_RESET;
    end else if (cfg_valid) begin
      word_max_r <= cfg_data;
    end
  end

  // anything above 256 behaves as 256
  assign word_limit = word_max_r[8] ? 9'd256 : word_max_r;

  assign s1_go     = s1_valid_r && (!buf_full || buf_pop);
  assign in_tready = !s1_valid_r || s1_go;

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_op_r   <= qwt_pkg::qwt_op_t'(in_tlast);
      s1_char_r <= in_tdata;
    end
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  qwt_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_go    (s1_go),
    .item_op    (s1_op_r),
    .item_char  (s1_char_r),
    .word_limit (word_limit),
    .res_valid  (res_valid),
    .res        (res)
  );

  qwt_out_buf u_out_buf (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (s1_go && res_valid),
    .push_data  (res),
    .full       (buf_full),
    .pop        (buf_pop),
    .head_valid (out_tvalid),
    .head_data  (head),
    .head_ready (out_tready)
  );

  assign out_tdata = {5'd0, head.word_quoted, head.word_length, head.word_stop,
                      head.word_start, head.cooked_char};
  assign out_tlast = head.word_end;
  assign out_tuser = {head.error_kind, head.char_valid};

endmodule

`default_nettype wire
